[hw/rtl/led_frame_orient_and_dim_unit_macros.svh]
// Assertion macros shared by the frame orientation and dimming unit.
// Each macro expects a clock named clk and an active-high reset named rst in scope.
`ifndef LED_FRAME_ORIENT_AND_DIM_UNIT_MACROS_SVH
`define LED_FRAME_ORIENT_AND_DIM_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LFOD_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lfod assertion failed");

// The consequent sequence starts in the cycle after the antecedent.
`define LFOD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
    else $error("lfod assertion failed");

`endif

[hw/rtl/lfod_pkg.sv]
`timescale 1ns / 1ps
package lfod_pkg;

  localparam int ROW_W      = 3;
  localparam int COL_W      = 5;
  localparam int CHAN_W     = 8;
  localparam int PIX_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [1:0] ROT_CW90  = 2'd1;
  localparam logic [1:0] ROT_180   = 2'd2;
  localparam logic [1:0] ROT_CW270 = 2'd3;

  localparam logic [1:0] LVL_DIM    = 2'd0;
  localparam logic [1:0] LVL_BRIGHT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROTATION     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_SELECT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_LEVEL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MEDIUM_LEVEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_LEVEL = 3'd4;

  typedef struct packed {
    logic             opcode;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] colour;
  } cmd_t;

  typedef struct packed {
    logic [ROW_W-1:0]  dest_row;
    logic [COL_W-1:0]  dest_col;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } result_t;

  typedef struct packed {
    logic [ROW_W-1:0] dest_row;
    logic [COL_W-1:0] dest_col;
  } dest_t;

endpackage

[hw/rtl/lfod_ram.sv]
`timescale 1ns / 1ps
module lfod_ram #(
  parameter int DATA_W = 24,
  parameter int DEPTH  = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [DATA_W-1:0]                     wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [DATA_W-1:0]                     rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/lfod_addr.sv]
`timescale 1ns / 1ps
module lfod_addr #(
  parameter int WIDTH_PX  = 32,
  parameter int HEIGHT_PX = 8
) (
  input  logic                                              opcode,
  input  logic [1:0]                                        rotation,
  input  logic [lfod_pkg::ROW_W-1:0]                        row,
  input  logic [lfod_pkg::COL_W-1:0]                        col,
  output logic                                              in_frame,
  output logic [$clog2(WIDTH_PX * HEIGHT_PX)-1:0]           addr
);

  localparam int SRW = $clog2(HEIGHT_PX);
  localparam int SCW = $clog2(WIDTH_PX);
  localparam int AW  = $clog2(WIDTH_PX * HEIGHT_PX);

  // Resampling tables for the quarter-turn rotations of a non-square frame.
  logic [SRW-1:0] col_row_fwd [2**lfod_pkg::COL_W];
  logic [SRW-1:0] col_row_rev [2**lfod_pkg::COL_W];
  logic [SCW-1:0] row_col_fwd [2**lfod_pkg::ROW_W];
  logic [SCW-1:0] row_col_rev [2**lfod_pkg::ROW_W];

  for (genvar i = 0; i < 2**lfod_pkg::COL_W; i++) begin : g_col_tbl
    localparam int FWD_RAW = i * HEIGHT_PX / WIDTH_PX;
    localparam int FWD     = (FWD_RAW > HEIGHT_PX - 1) ? HEIGHT_PX - 1 : FWD_RAW;
    localparam int REV_RAW = (i < WIDTH_PX) ? (WIDTH_PX - 1 - i) * HEIGHT_PX / WIDTH_PX : 0;
    localparam int REV     = (REV_RAW > HEIGHT_PX - 1) ? HEIGHT_PX - 1 : REV_RAW;
    assign col_row_fwd[i] = SRW'(FWD);
    assign col_row_rev[i] = SRW'(REV);
  end

  for (genvar i = 0; i < 2**lfod_pkg::ROW_W; i++) begin : g_row_tbl
    localparam int FWD_RAW = i * WIDTH_PX / HEIGHT_PX;
    localparam int FWD     = (FWD_RAW > WIDTH_PX - 1) ? WIDTH_PX - 1 : FWD_RAW;
    localparam int REV_RAW = (i < HEIGHT_PX) ? (HEIGHT_PX - 1 - i) * WIDTH_PX / HEIGHT_PX : 0;
    localparam int REV     = (REV_RAW > WIDTH_PX - 1) ? WIDTH_PX - 1 : REV_RAW;
    assign row_col_fwd[i] = SCW'(FWD);
    assign row_col_rev[i] = SCW'(REV);
  end

  logic [SRW-1:0] sr_map;
  logic [SCW-1:0] sc_map;
  logic [SRW-1:0] sr_fin;
  logic [SCW-1:0] sc_fin;

  always_comb begin
    case (rotation)
      lfod_pkg::ROT_CW90: begin
        sr_map = col_row_rev[col];
        sc_map = row_col_fwd[row];
      end
      lfod_pkg::ROT_180: begin
        sr_map = SRW'(HEIGHT_PX - 1) - SRW'(row);
        sc_map = SCW'(WIDTH_PX - 1) - SCW'(col);
      end
      lfod_pkg::ROT_CW270: begin
        sr_map = col_row_fwd[col];
        sc_map = row_col_rev[row];
      end
      default: begin
        sr_map = SRW'(row);
        sc_map = SCW'(col);
      end
    endcase

    // Writes land where they are addressed; reads go through the rotation and
    // the vertical mirror that the panel mounting needs.
    if (opcode == lfod_pkg::OP_WRITE) begin
      sr_fin = SRW'(row);
      sc_fin = SCW'(col);
    end else begin
      sr_fin = SRW'(HEIGHT_PX - 1) - sr_map;
      sc_fin = sc_map;
    end
  end

  assign in_frame = (32'(row) < 32'(HEIGHT_PX)) && (32'(col) < 32'(WIDTH_PX));
  assign addr     = AW'(sr_fin) * AW'(WIDTH_PX) + AW'(sc_fin);

endmodule

[hw/rtl/lfod_scale.sv]
`timescale 1ns / 1ps
module lfod_scale (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  lfod_pkg::dest_t                in_dest,
  input  logic [lfod_pkg::PIX_W-1:0]     pixel,
  input  logic [lfod_pkg::CHAN_W-1:0]    level,
  output logic                           out_valid,
  output lfod_pkg::result_t              out_result
);

  localparam int PW = 2 * lfod_pkg::CHAN_W;

  // Rounded divide by 255 of value*level + 127, exact for any product of two 8-bit values.
  function automatic logic [lfod_pkg::CHAN_W-1:0] div255(input logic [PW-1:0] prod);
    logic [PW-1:0] x;
    logic [PW:0]   s;
    x = prod + PW'(127);
    s = (PW+1)'(x) + (PW+1)'(x >> 8) + (PW+1)'(1);
    return s[15:8];
  endfunction

  logic            prod_valid;
  lfod_pkg::dest_t prod_dest;
  logic [PW-1:0]   prod_r;
  logic [PW-1:0]   prod_g;
  logic [PW-1:0]   prod_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      prod_valid <= in_valid;
      out_valid  <= prod_valid;
    end
    prod_dest <= in_dest;
    prod_r    <= PW'(pixel[23:16]) * PW'(level);
    prod_g    <= PW'(pixel[15:8]) * PW'(level);
    prod_b    <= PW'(pixel[7:0]) * PW'(level);
    out_result.dest_row <= prod_dest.dest_row;
    out_result.dest_col <= prod_dest.dest_col;
    out_result.red      <= div255(prod_r);
    out_result.green    <= div255(prod_g);
    out_result.blue     <= div255(prod_b);
  end

endmodule

[hw/rtl/led_frame_orient_and_dim_unit.sv]
`timescale 1ns / 1ps
`include "led_frame_orient_and_dim_unit_macros.svh"
// Frame store for a small LED matrix. After reset the block holds busy high while it
// sweeps all WIDTH_PX*HEIGHT_PX pixels of the store to black, one pixel per cycle.
// From then on it takes one transaction per cycle: a write transaction stores a
// pixel if it lies inside the frame and gives no result; a read transaction gives
// exactly one result, on the result ports for a single cycle with result_valid high,
// after the s1 and s2 registers and the product and output registers of lfod_scale.
// Results come out in order and cannot be held off, so the receiver must take each
// one in the cycle it appears. The rate is set by the pixel memory, which takes one
// write and one read per cycle and which every transaction uses at most once.
// Configuration writes are taken at any time but belong only in idle periods.
module led_frame_orient_and_dim_unit #(
  parameter int WIDTH_PX  = 32,
  parameter int HEIGHT_PX = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  lfod_pkg::cmd_t                      cmd,
  output logic                                result_valid,
  output lfod_pkg::result_t                   result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lfod_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lfod_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int DEPTH = WIDTH_PX * HEIGHT_PX;
  localparam int AW    = $clog2(DEPTH);

  logic [1:0]                  rotation;
  logic [1:0]                  level_select;
  logic [lfod_pkg::CHAN_W-1:0] dim_level;
  logic [lfod_pkg::CHAN_W-1:0] medium_level;
  logic [lfod_pkg::CHAN_W-1:0] bright_level;

  logic          clearing;
  logic [AW-1:0] clr_addr;
  logic          accept;

  logic          map_inside;
  logic [AW-1:0] map_addr;

  logic                       s1_valid;
  logic                       s1_opcode;
  logic                       s1_inside;
  logic [AW-1:0]              s1_addr;
  logic [lfod_pkg::PIX_W-1:0] s1_colour;
  lfod_pkg::dest_t            s1_dest;

  logic            s2_valid;
  logic            s2_inside;
  lfod_pkg::dest_t s2_dest;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [lfod_pkg::PIX_W-1:0]  ram_wdata;
  logic [lfod_pkg::PIX_W-1:0]  ram_rdata;
  logic [lfod_pkg::PIX_W-1:0]  pixel;
  logic [lfod_pkg::CHAN_W-1:0] level;

  assign cfg_ready = 1'b1;
  assign busy      = clearing;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation     <= 2'd0;
      level_select <= 2'd1;
      dim_level    <= 8'd16;
      medium_level <= 8'd64;
      bright_level <= 8'd255;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lfod_pkg::REG_ROTATION:     rotation     <= cfg_data[1:0];
        lfod_pkg::REG_LEVEL_SELECT: level_select <= cfg_data[1:0];
        lfod_pkg::REG_DIM_LEVEL:    dim_level    <= cfg_data;
        lfod_pkg::REG_MEDIUM_LEVEL: medium_level <= cfg_data;
        lfod_pkg::REG_BRIGHT_LEVEL: bright_level <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  lfod_addr #(
    .WIDTH_PX  (WIDTH_PX),
    .HEIGHT_PX (HEIGHT_PX)
  ) u_addr (
    .opcode   (cmd.opcode),
    .rotation (rotation),
    .row      (cmd.row),
    .col      (cmd.col),
    .in_frame (map_inside),
    .addr     (map_addr)
  );

  // Each transaction touches the memory at most once, in acceptance order, so a
  // read that follows a write always sees the written pixel.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid && (s1_opcode == lfod_pkg::OP_READ);
    end
    s1_opcode        <= cmd.opcode;
    s1_inside        <= map_inside;
    s1_addr          <= map_addr;
    s1_colour        <= cmd.colour;
    s1_dest.dest_row <= cmd.row;
    s1_dest.dest_col <= cmd.col;
    s2_inside        <= s1_inside;
    s2_dest          <= s1_dest;
  end

  assign ram_we    = clearing || (s1_valid && (s1_opcode == lfod_pkg::OP_WRITE) && s1_inside);
  assign ram_waddr = clearing ? clr_addr : s1_addr;
  assign ram_wdata = clearing ? '0 : s1_colour;

  lfod_ram #(
    .DATA_W (lfod_pkg::PIX_W),
    .DEPTH  (DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (s1_addr),
    .rdata (ram_rdata)
  );

  // A read outside the frame shows black.
  assign pixel = s2_inside ? ram_rdata : '0;

  always_comb begin
    case (level_select)
      lfod_pkg::LVL_DIM:    level = dim_level;
      lfod_pkg::LVL_BRIGHT: level = bright_level;
      default:              level = medium_level;
    endcase
  end

  lfod_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s2_valid),
    .in_dest    (s2_dest),
    .pixel      (pixel),
    .level      (level),
    .out_valid  (result_valid),
    .out_result (result)
  );

  `LFOD_ASSERT_NEXT(a_read_gives_result, accept && cmd.opcode == lfod_pkg::OP_READ, ##3 result_valid)
  `LFOD_ASSERT_IMPLIES(a_result_from_read, result_valid, $past(accept && cmd.opcode == lfod_pkg::OP_READ, 4))
  `LFOD_ASSERT_IMPLIES(a_no_item_while_clearing, clearing, !s1_valid && !s2_valid)
  `LFOD_ASSERT_IMPLIES(a_outside_is_black, result_valid && (32'(result.dest_row) >= 32'(HEIGHT_PX) || 32'(result.dest_col) >= 32'(WIDTH_PX)), result.red == '0 && result.green == '0 && result.blue == '0)

endmodule
